/* rtl/bcs_pkg.sv */
`default_nettype none

package bcs_pkg;

	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_DATA_BITS  = 16;
	localparam int DEF_FRAC_BITS  = 8;

	// signed plane position, wide enough for row*step - pad + floor(shift)
	localparam int PosW     = 12;
	localparam int ShiftW   = 14;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 14;

	typedef enum logic [CfgIdxW-1:0] {
		REG_IN_HEIGHT   = 3'd0,
		REG_IN_WIDTH    = 3'd1,
		REG_PAD_ROWS    = 3'd2,
		REG_PAD_COLS    = 3'd3,
		REG_STEP_ROWS   = 3'd4,
		REG_STEP_COLS   = 3'd5,
		REG_SHIFT_HORIZ = 3'd6,
		REG_SHIFT_VERT  = 3'd7
	} bcs_reg_t;

	typedef enum logic {
		REQ_WRITE   = 1'b0,
		REQ_COMPUTE = 1'b1
	} bcs_req_t;

	// stage 1 control toward the plane banks; bank index is {row parity, col parity}
	typedef struct packed {
		logic       cmp;
		logic       wr;
		logic [1:0] wr_bank;
		logic [3:0] bank_ok;
		logic [1:0] par;
	} bcs_ctl_t;

endpackage

`default_nettype wire

/* rtl/bcs_addr.sv */
`default_nettype none

module bcs_addr #(
	parameter int MAX_HEIGHT = bcs_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH  = bcs_pkg::DEF_MAX_WIDTH,
	parameter int DATA_BITS  = bcs_pkg::DEF_DATA_BITS,
	parameter int AW         = 1
) (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic                             req_type,
	input  wire logic [5:0]                       write_row,
	input  wire logic [5:0]                       write_col,
	input  wire logic signed [DATA_BITS-1:0]      pixel_value,
	input  wire logic [5:0]                       out_row,
	input  wire logic [5:0]                       out_col,
	input  wire logic [6:0]                       in_height,
	input  wire logic [6:0]                       in_width,
	input  wire logic [4:0]                       pad_rows,
	input  wire logic [4:0]                       pad_cols,
	input  wire logic [3:0]                       step_rows,
	input  wire logic [3:0]                       step_cols,
	input  wire logic signed [bcs_pkg::PosW-1:0]  floor_x,
	input  wire logic signed [bcs_pkg::PosW-1:0]  floor_y,
	output bcs_pkg::bcs_ctl_t                     ctl,
	output logic [AW-1:0]                         wr_addr,
	output logic [DATA_BITS-1:0]                  wr_data,
	output logic [3:0][AW-1:0]                    rd_addr
);
	import bcs_pkg::*;

	localparam int HALF_W = (MAX_WIDTH + 1) / 2;

	logic [9:0]             row_scaled, col_scaled;
	logic signed [PosW-1:0] h0_d, w0_d;
	logic                   wr_ok;
	logic [AW-1:0]          wr_addr_d;

	logic                   cmp_s1, wr_s1;
	logic [1:0]             wr_bank_s1;
	logic [AW-1:0]          wr_addr_s1;
	logic [DATA_BITS-1:0]   wr_data_s1;
	logic signed [PosW-1:0] h0_s1, w0_s1, h1_s1, w1_s1;

	logic [PosW-1:0]        rows_lim, cols_lim;
	logic                   rv0, rv1, cv0, cv1;
	logic [PosW-1:0]        rh_odd, rh_even, ch_odd, ch_even;
	logic [3:0]             bank_ok;

	assign row_scaled = 10'(out_row) * 10'(step_rows);
	assign col_scaled = 10'(out_col) * 10'(step_cols);
	assign h0_d = signed'(PosW'(row_scaled)) - signed'(PosW'(pad_rows)) + floor_y;
	assign w0_d = signed'(PosW'(col_scaled)) - signed'(PosW'(pad_cols)) + floor_x;

	assign wr_ok = (bcs_req_t'(req_type) == REQ_WRITE)
		&& (32'(write_row) < MAX_HEIGHT) && (32'(write_col) < MAX_WIDTH);
	assign wr_addr_d = AW'(32'(write_row >> 1) * HALF_W + 32'(write_col >> 1));

	always_ff @(posedge clk) begin
		if (en) begin
			cmp_s1     <= (bcs_req_t'(req_type) == REQ_COMPUTE);
			wr_s1      <= wr_ok;
			wr_bank_s1 <= {write_row[0], write_col[0]};
			wr_addr_s1 <= wr_addr_d;
			wr_data_s1 <= pixel_value;
			h0_s1      <= h0_d;
			w0_s1      <= w0_d;
		end
	end

	assign rows_lim = (32'(in_height) > MAX_HEIGHT) ? PosW'(MAX_HEIGHT) : PosW'(in_height);
	assign cols_lim = (32'(in_width) > MAX_WIDTH) ? PosW'(MAX_WIDTH) : PosW'(in_width);

	assign h1_s1 = h0_s1 + signed'(PosW'(1));
	assign w1_s1 = w0_s1 + signed'(PosW'(1));

	assign rv0 = (h0_s1 >= 0) && (h0_s1 < signed'(rows_lim));
	assign rv1 = (h1_s1 >= 0) && (h1_s1 < signed'(rows_lim));
	assign cv0 = (w0_s1 >= 0) && (w0_s1 < signed'(cols_lim));
	assign cv1 = (w1_s1 >= 0) && (w1_s1 < signed'(cols_lim));

	// odd bank holds the odd one of the two rows, even bank the even one
	assign rh_odd  = PosW'(h0_s1 >>> 1);
	assign rh_even = rh_odd + PosW'(h0_s1[0]);
	assign ch_odd  = PosW'(w0_s1 >>> 1);
	assign ch_even = ch_odd + PosW'(w0_s1[0]);

	always_comb begin
		logic [1:0]      b2;
		logic            row_hit, col_hit;
		logic [PosW-1:0] rh, ch;
		for (int b = 0; b < 4; b++) begin
			b2         = 2'(b);
			row_hit    = (b2[1] == h0_s1[0]) ? rv0 : rv1;
			col_hit    = (b2[0] == w0_s1[0]) ? cv0 : cv1;
			rh         = b2[1] ? rh_odd : rh_even;
			ch         = b2[0] ? ch_odd : ch_even;
			bank_ok[b] = row_hit && col_hit;
			rd_addr[b] = bank_ok[b] ? AW'(32'(rh) * HALF_W + 32'(ch)) : '0;
		end
	end

	assign ctl.cmp     = cmp_s1;
	assign ctl.wr      = wr_s1;
	assign ctl.wr_bank = wr_bank_s1;
	assign ctl.bank_ok = bank_ok;
	assign ctl.par     = {h0_s1[0], w0_s1[0]};
	assign wr_addr     = wr_addr_s1;
	assign wr_data     = wr_data_s1;

endmodule

`default_nettype wire

/* rtl/bcs_store.sv */
`default_nettype none

module bcs_store #(
	parameter int MAX_HEIGHT = bcs_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH  = bcs_pkg::DEF_MAX_WIDTH,
	parameter int DATA_BITS  = bcs_pkg::DEF_DATA_BITS,
	parameter int AW         = 1
) (
	input  wire logic                    clk,
	input  wire logic                    valid,
	input  wire logic                    en,
	input  wire bcs_pkg::bcs_ctl_t       ctl,
	input  wire logic [AW-1:0]           wr_addr,
	input  wire logic [DATA_BITS-1:0]    wr_data,
	input  wire logic [3:0][AW-1:0]      rd_addr,
	output logic [3:0][DATA_BITS-1:0]    bank_data,
	output logic [1:0]                   par_s2
);
	import bcs_pkg::*;

	localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
	localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
	localparam int BANK_DEPTH = HALF_H * HALF_W;

	logic [3:0] ok_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s2  <= ctl.bank_ok;
			par_s2 <= ctl.par;
		end
	end

	// 2x2 interleave: the four neighbors always sit in four different banks
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [DATA_BITS-1:0] mem [BANK_DEPTH];
		logic [DATA_BITS-1:0] rd_s2;

		always_ff @(posedge clk) begin
			if (valid && en && ctl.wr && (ctl.wr_bank == 2'(b))) begin
				mem[wr_addr] <= wr_data;
			end
			if (en) begin
				rd_s2 <= mem[rd_addr[b]];
			end
		end

		assign bank_data[b] = ok_s2[b] ? rd_s2 : '0;
	end

endmodule

`default_nettype wire

/* rtl/bcs_blend.sv */
`default_nettype none

module bcs_blend #(
	parameter int DATA_BITS = bcs_pkg::DEF_DATA_BITS,
	parameter int FRAC_BITS = bcs_pkg::DEF_FRAC_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         en_s3,
	input  wire logic                         en_s4,
	input  wire logic [3:0][DATA_BITS-1:0]    bank_data,
	input  wire logic [1:0]                   par,
	input  wire logic [FRAC_BITS-1:0]         frac_x,
	input  wire logic [FRAC_BITS-1:0]         frac_y,
	output logic signed [DATA_BITS-1:0]       shifted_value
);
	localparam int ONE = 2 ** FRAC_BITS;
	localparam int WW  = FRAC_BITS + 2;
	localparam int TW  = DATA_BITS + FRAC_BITS + 2;
	localparam int SW  = TW + FRAC_BITS + 2;

	logic signed [DATA_BITS-1:0] q11, q21, q12, q22;
	logic signed [WW-1:0]        wx0, wx1, wy0, wy1;
	logic signed [TW-1:0]        top_d, bot_d, top_s3, bot_s3;
	logic signed [SW-1:0]        sum_d, res_d;
	logic signed [DATA_BITS-1:0] value_s4;

	// neighbor (i,j) lives in bank {row parity ^ i, col parity ^ j}
	assign q11 = signed'(bank_data[{par[1], par[0]}]);
	assign q21 = signed'(bank_data[{par[1], ~par[0]}]);
	assign q12 = signed'(bank_data[{~par[1], par[0]}]);
	assign q22 = signed'(bank_data[{~par[1], ~par[0]}]);

	assign wx1 = signed'(WW'(frac_x));
	assign wx0 = signed'(WW'(ONE)) - wx1;
	assign wy1 = signed'(WW'(frac_y));
	assign wy0 = signed'(WW'(ONE)) - wy1;

	assign top_d = TW'(q11) * TW'(wx0) + TW'(q21) * TW'(wx1);
	assign bot_d = TW'(q12) * TW'(wx0) + TW'(q22) * TW'(wx1);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			top_s3 <= top_d;
			bot_s3 <= bot_d;
		end
	end

	assign sum_d = SW'(top_s3) * SW'(wy0) + SW'(bot_s3) * SW'(wy1);
	assign res_d = sum_d >>> (2 * FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			value_s4 <= DATA_BITS'(res_d);
		end
	end

	assign shifted_value = value_s4;

endmodule

`default_nettype wire

/* rtl/bilinear_channel_shift.sv */
// Bilinear channel shift over one stored feature-map plane.
// Input channel (in_valid/in_ready): req_type selects a pixel write
// (write_row, write_col, pixel_value) or a compute (out_row, out_col).
// A write yields no item on the output; a compute yields one
// shifted_value on the output channel (out_valid/out_ready), in order.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. The plane is split into four banks by
// row and column parity, so the four neighbors come from four reads in
// one cycle.
// A compute passes four registered stages before out_valid rises:
// address calc, bank read, horizontal blend, vertical blend.
// A write is visible to any compute accepted after it.
// Reset: config returns to defaults, the pipeline empties; plane
// contents are undefined until written.
// Output stall: stages hold and fill; in_ready drops once all four
// stages are full.
`default_nettype none

module bilinear_channel_shift #(
	parameter int MAX_HEIGHT = bcs_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH  = bcs_pkg::DEF_MAX_WIDTH,
	parameter int DATA_BITS  = bcs_pkg::DEF_DATA_BITS,
	parameter int FRAC_BITS  = bcs_pkg::DEF_FRAC_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [bcs_pkg::CfgIdxW-1:0]       cfg_index,
	input  wire logic [bcs_pkg::CfgDataW-1:0]      cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              req_type,
	input  wire logic [5:0]                        write_row,
	input  wire logic [5:0]                        write_col,
	input  wire logic signed [DATA_BITS-1:0]       pixel_value,
	input  wire logic [5:0]                        out_row,
	input  wire logic [5:0]                        out_col,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [DATA_BITS-1:0]            shifted_value
);
	import bcs_pkg::*;

	localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
	localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
	localparam int BANK_DEPTH = HALF_H * HALF_W;
	localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int EW         = (ShiftW > FRAC_BITS) ? ShiftW : FRAC_BITS + 1;

	logic [6:0]               in_height_q, in_width_q;
	logic [4:0]               pad_rows_q, pad_cols_q;
	logic [3:0]               step_rows_q, step_cols_q;
	logic signed [ShiftW-1:0] shift_horiz_q, shift_vert_q;

	logic signed [EW-1:0]     sx_ext, sy_ext, flx_full, fly_full;
	logic signed [PosW-1:0]   floor_x, floor_y;
	logic [FRAC_BITS-1:0]     frac_x, frac_y;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	bcs_ctl_t                   ctl;
	logic [AW-1:0]              wr_addr;
	logic [DATA_BITS-1:0]       wr_data;
	logic [3:0][AW-1:0]         rd_addr;
	logic [3:0][DATA_BITS-1:0]  bank_data;
	logic [1:0]                 par_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q   <= 7'd64;
			in_width_q    <= 7'd64;
			pad_rows_q    <= '0;
			pad_cols_q    <= '0;
			step_rows_q   <= 4'd1;
			step_cols_q   <= 4'd1;
			shift_horiz_q <= '0;
			shift_vert_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (bcs_reg_t'(cfg_index))
				REG_IN_HEIGHT:   in_height_q   <= cfg_data[6:0];
				REG_IN_WIDTH:    in_width_q    <= cfg_data[6:0];
				REG_PAD_ROWS:    pad_rows_q    <= cfg_data[4:0];
				REG_PAD_COLS:    pad_cols_q    <= cfg_data[4:0];
				REG_STEP_ROWS:   step_rows_q   <= cfg_data[3:0];
				REG_STEP_COLS:   step_cols_q   <= cfg_data[3:0];
				REG_SHIFT_HORIZ: shift_horiz_q <= signed'(cfg_data[ShiftW-1:0]);
				REG_SHIFT_VERT:  shift_vert_q  <= signed'(cfg_data[ShiftW-1:0]);
				default: ;
			endcase
		end
	end

	// floor and fraction of the fixed-point shifts
	assign sx_ext   = EW'(shift_horiz_q);
	assign sy_ext   = EW'(shift_vert_q);
	assign frac_x   = sx_ext[FRAC_BITS-1:0];
	assign frac_y   = sy_ext[FRAC_BITS-1:0];
	assign flx_full = sx_ext >>> FRAC_BITS;
	assign fly_full = sy_ext >>> FRAC_BITS;
	assign floor_x  = PosW'(flx_full);
	assign floor_y  = PosW'(fly_full);

	assign en_s4    = !valid_s4 || out_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1 && ctl.cmp;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	bcs_addr #(
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_WIDTH  (MAX_WIDTH),
		.DATA_BITS  (DATA_BITS),
		.AW         (AW)
	) u_addr (
		.clk         (clk),
		.en          (en_s1),
		.req_type    (req_type),
		.write_row   (write_row),
		.write_col   (write_col),
		.pixel_value (pixel_value),
		.out_row     (out_row),
		.out_col     (out_col),
		.in_height   (in_height_q),
		.in_width    (in_width_q),
		.pad_rows    (pad_rows_q),
		.pad_cols    (pad_cols_q),
		.step_rows   (step_rows_q),
		.step_cols   (step_cols_q),
		.floor_x     (floor_x),
		.floor_y     (floor_y),
		.ctl         (ctl),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_addr     (rd_addr)
	);

	bcs_store #(
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_WIDTH  (MAX_WIDTH),
		.DATA_BITS  (DATA_BITS),
		.AW         (AW)
	) u_store (
		.clk       (clk),
		.valid     (valid_s1),
		.en        (en_s2),
		.ctl       (ctl),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.bank_data (bank_data),
		.par_s2    (par_s2)
	);

	bcs_blend #(
		.DATA_BITS (DATA_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_blend (
		.clk           (clk),
		.en_s3         (en_s3),
		.en_s4         (en_s4),
		.bank_data     (bank_data),
		.par           (par_s2),
		.frac_x        (frac_x),
		.frac_y        (frac_y),
		.shifted_value (shifted_value)
	);

	assign out_valid = valid_s4;

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4))
		else $error("input stalled with a free stage");

	a_write_retires: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && en_s2 && !ctl.cmp) |=> !valid_s2)
		else $error("write item reached the read stage");

	a_blend_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && en_s4) |=> out_valid)
		else $error("blended item lost before output");

endmodule

`default_nettype wire

/* tb/tb.sv */
module tb;
	import bcs_pkg::*;

	localparam int FRAC = DEF_FRAC_BITS;
	localparam int MAXH = DEF_MAX_HEIGHT;
	localparam int MAXW = DEF_MAX_WIDTH;
	localparam longint ONE = longint'(1) << FRAC;

	typedef struct {
		logic [6:0]         height;
		logic [6:0]         width;
		logic [4:0]         pad_r;
		logic [4:0]         pad_c;
		logic [3:0]         step_r;
		logic [3:0]         step_c;
		logic signed [13:0] shift_h;
		logic signed [13:0] shift_v;
	} shift_cfg_t;

	typedef struct {
		bcs_req_t           kind;
		logic [5:0]         wr_row;
		logic [5:0]         wr_col;
		logic signed [15:0] pixel;
		logic [5:0]         o_row;
		logic [5:0]         o_col;
	} plane_req_t;

	typedef enum {RX_FREE, RX_HALF, RX_SPARSE, RX_PULSE} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic req_type = 1'b0;
	logic [5:0] write_row = '0;
	logic [5:0] write_col = '0;
	logic signed [15:0] pixel_value = '0;
	logic [5:0] out_row = '0;
	logic [5:0] out_col = '0;
	logic out_ready = 1'b0;
	logic cfg_ready;
	logic in_ready;
	logic out_valid;
	logic signed [15:0] shifted_value;

	bilinear_channel_shift dut (.*);

	always #1 clk = ~clk;

	// expected side
	shift_cfg_t model_cfg = '{7'd64, 7'd64, 5'd0, 5'd0, 4'd1, 4'd1, 14'sd0, 14'sd0};
	logic signed [15:0] plane_mem [MAXH*MAXW];
	logic signed [15:0] shifted_q [$];
	int errors = 0;

	// stimulus side
	shift_cfg_t gen_cfg = '{7'd64, 7'd64, 5'd0, 5'd0, 4'd1, 4'd1, 14'sd0, 14'sd0};
	bit gen_written [MAXH*MAXW];
	plane_req_t req_q [$];

	// handshake bookkeeping
	bit in_taken = 1'b0;
	plane_req_t drv_item;
	int gap_left = 0;
	int burst_left = 0;
	int hold_asks = 0;
	int holds_done = 0;
	int hold_left = 0;
	int rx_tick = 0;
	rx_mode_t rx_mode = RX_FREE;
	logic signed [15:0] want;

	function automatic void apply_reg(inout shift_cfg_t cfg, input bcs_reg_t idx,
			input logic [CfgDataW-1:0] data);
		case (idx)
		REG_IN_HEIGHT:   cfg.height = data[6:0];
		REG_IN_WIDTH:    cfg.width = data[6:0];
		REG_PAD_ROWS:    cfg.pad_r = data[4:0];
		REG_PAD_COLS:    cfg.pad_c = data[4:0];
		REG_STEP_ROWS:   cfg.step_r = data[3:0];
		REG_STEP_COLS:   cfg.step_c = data[3:0];
		REG_SHIFT_HORIZ: cfg.shift_h = data;
		REG_SHIFT_VERT:  cfg.shift_v = data;
		default: ;
		endcase
	endfunction

	function automatic longint span_of(input logic [6:0] n, input longint lim);
		return (n > lim) ? lim : longint'(n);
	endfunction

	function automatic bit in_plane(input shift_cfg_t cfg, input longint h, input longint w);
		return h >= 0 && w >= 0 && h < span_of(cfg.height, MAXH) && w < span_of(cfg.width, MAXW);
	endfunction

	// top-left neighbor: row*step - pad + floor(shift)
	function automatic void base_corner(input shift_cfg_t cfg, input logic [5:0] r,
			input logic [5:0] c, output longint h0, output longint w0);
		longint fl_r, fl_c;
		fl_r = cfg.shift_v;
		fl_r = fl_r >>> FRAC;
		fl_c = cfg.shift_h;
		fl_c = fl_c >>> FRAC;
		h0 = longint'(r) * longint'(cfg.step_r) - longint'(cfg.pad_r) + fl_r;
		w0 = longint'(c) * longint'(cfg.step_c) - longint'(cfg.pad_c) + fl_c;
	endfunction

	function automatic logic signed [15:0] bilinear_at(input logic [5:0] r, input logic [5:0] c);
		longint h0, w0, fx, fy, acc;
		longint px [4];
		fx = model_cfg.shift_h;
		fx = fx & (ONE - 1);
		fy = model_cfg.shift_v;
		fy = fy & (ONE - 1);
		base_corner(model_cfg, r, c, h0, w0);
		for (int i = 0; i < 4; i++) begin
			if (in_plane(model_cfg, h0 + i / 2, w0 + i % 2)) begin
				px[i] = plane_mem[(h0 + i / 2) * MAXW + w0 + i % 2];
			end else begin
				px[i] = 0;
			end
		end
		acc = px[0] * (ONE - fx) * (ONE - fy) + px[1] * fx * (ONE - fy)
			+ px[2] * (ONE - fx) * fy + px[3] * fx * fy;
		acc = acc >>> (2 * FRAC);
		return acc[15:0];
	endfunction

	function automatic logic signed [15:0] rand_pixel();
		case ($urandom_range(0, 7))
		0: return 16'sh8000;
		1: return 16'sh7fff;
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic void push_write(input logic [5:0] r, input logic [5:0] c,
			input logic signed [15:0] v);
		plane_req_t it;
		it.kind = REQ_WRITE;
		it.wr_row = r;
		it.wr_col = c;
		it.pixel = v;
		it.o_row = 6'($urandom);
		it.o_col = 6'($urandom);
		req_q.push_back(it);
		gen_written[{r, c}] = 1'b1;
	endfunction

	// fills any unwritten neighbor inside the plane first
	function automatic void push_compute(input logic [5:0] r, input logic [5:0] c);
		plane_req_t it;
		longint h0, w0, h, w;
		base_corner(gen_cfg, r, c, h0, w0);
		for (int i = 0; i < 4; i++) begin
			h = h0 + i / 2;
			w = w0 + i % 2;
			if (in_plane(gen_cfg, h, w) && !gen_written[h * MAXW + w])
				push_write(h[5:0], w[5:0], rand_pixel());
		end
		it.kind = REQ_COMPUTE;
		it.wr_row = 6'($urandom);
		it.wr_col = 6'($urandom);
		it.pixel = 16'($urandom);
		it.o_row = r;
		it.o_col = c;
		req_q.push_back(it);
	endfunction

	// output coordinate whose neighbors land on or next to the plane
	function automatic logic [5:0] aim(input longint span, input longint pad,
			input longint step, input logic signed [13:0] shift);
		longint t, fl;
		if (step == 0)
			return 6'($urandom);
		fl = shift;
		fl = fl >>> FRAC;
		t = longint'($urandom_range(0, 32'(span) + 1)) - 1 + pad - fl;
		t = t / step;
		if (t < 0)
			t = 0;
		if (t > 63)
			t = 63;
		return t[5:0];
	endfunction

	function automatic void random_items(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 35) begin
				push_write(6'($urandom), 6'($urandom), rand_pixel());
			end else if ($urandom_range(0, 3) == 0) begin
				push_compute(6'($urandom), 6'($urandom));
			end else begin
				push_compute(
					aim(span_of(gen_cfg.height, MAXH), gen_cfg.pad_r, gen_cfg.step_r,
						gen_cfg.shift_v),
					aim(span_of(gen_cfg.width, MAXW), gen_cfg.pad_c, gen_cfg.step_c,
						gen_cfg.shift_h));
			end
		end
	endfunction

	// junk above each register's width must be dropped
	task automatic set_plane_cfg(input int h, input int w, input int pr, input int pc,
			input int sr, input int sc, input int sh, input int sv);
		int vals [8];
		logic [CfgDataW-1:0] data;
		vals = '{h, w, pr, pc, sr, sc, sh, sv};
		for (int i = 0; i < 8; i++) begin
			data = CfgDataW'(vals[i]);
			case (bcs_reg_t'(i))
			REG_IN_HEIGHT, REG_IN_WIDTH: data[13:7] = 7'($urandom);
			REG_PAD_ROWS, REG_PAD_COLS: data[13:5] = 9'($urandom);
			REG_STEP_ROWS, REG_STEP_COLS: data[13:4] = 10'($urandom);
			default: ;
			endcase
			apply_reg(gen_cfg, bcs_reg_t'(i), data);
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= bcs_reg_t'(i);
			cfg_data <= data;
			do @(posedge clk); while (!cfg_ready);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		do @(posedge clk); while (req_q.size() != 0 || in_valid || shifted_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// model update and result check
	always @(posedge clk) begin
		in_taken = in_valid && in_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_reg(model_cfg, bcs_reg_t'(cfg_index), cfg_data);
			if (in_taken) begin
				if (bcs_req_t'(req_type) == REQ_WRITE) begin
					plane_mem[{write_row, write_col}] = pixel_value;
				end else begin
					shifted_q.push_back(bilinear_at(out_row, out_col));
				end
			end
			if (out_valid && out_ready) begin
				if (shifted_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected item, shifted_value %0d", $time, shifted_value);
				end else begin
					want = shifted_q.pop_front();
					if (shifted_value !== want) begin
						errors++;
						if (errors <= 10)
							$display("%0t: shifted_value expected %0d, got %0d",
								$time, want, shifted_value);
					end
				end
			end
		end
	end

	// sender: bursts with gaps
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (req_q.size() != 0) begin
				drv_item = req_q.pop_front();
				in_valid <= 1'b1;
				req_type <= drv_item.kind;
				write_row <= drv_item.wr_row;
				write_col <= drv_item.wr_col;
				pixel_value <= drv_item.pixel;
				out_row <= drv_item.o_row;
				out_col <= drv_item.o_col;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 24);
					gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern plus long holds
	always @(negedge clk) begin
		rx_tick++;
		if (rx_tick % 64 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		if (hold_left == 0 && holds_done != hold_asks) begin
			holds_done++;
			hold_left = 150;
		end else if (hold_left == 0 && $urandom_range(0, 299) == 0) begin
			hold_left = $urandom_range(20, 80);
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
			RX_FREE:   out_ready <= 1'b1;
			RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default:   out_ready <= rx_tick[2];
			endcase
		end
	end

	initial begin
		#1000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, extreme pixels at the corners
		push_write(6'd0, 6'd0, 16'sh8000);
		push_write(6'd0, 6'd63, 16'sh7fff);
		push_write(6'd63, 6'd0, 16'sh7fff);
		push_write(6'd63, 6'd63, 16'sh8000);
		push_compute(6'd0, 6'd0);
		push_compute(6'd63, 6'd63);
		push_compute(6'd0, 6'd63);
		push_compute(6'd63, 6'd0);
		push_compute(6'd31, 6'd17);
		drain();

		set_plane_cfg(64, 64, 0, 0, 1, 1, 128, 64);
		random_items(100);
		hold_asks++;
		drain();

		// largest pad, stride 8, most negative and most positive shift
		set_plane_cfg(64, 64, 31, 31, 8, 8, -8192, 8191);
		push_compute(6'd4, 6'd8);
		push_compute(6'd7, 6'd12);
		push_compute(6'd0, 6'd0);
		push_compute(6'd63, 6'd63);
		random_items(100);
		drain();

		// one-pixel plane, shifts just below zero
		set_plane_cfg(1, 1, 0, 0, 1, 1, -128, -1);
		push_compute(6'd0, 6'd0);
		push_compute(6'd1, 6'd1);
		push_compute(6'd0, 6'd1);
		push_compute(6'd63, 6'd63);
		random_items(60);
		drain();

		// zero height: every neighbor reads as zero
		set_plane_cfg(0, 64, 0, 0, 1, 1, 64, 32);
		push_compute(6'd0, 6'd0);
		push_compute(6'd5, 6'd5);
		random_items(40);
		drain();

		// sizes past the store saturate; zero row stride, widest column stride
		set_plane_cfg(100, 127, 0, 3, 0, 15, -300, 700);
		push_compute(6'd0, 6'd0);
		push_compute(6'd63, 6'd1);
		push_compute(6'd17, 6'd0);
		random_items(80);
		drain();

		repeat (6) begin
			set_plane_cfg($urandom_range(1, 64), $urandom_range(1, 64),
				$urandom_range(0, 31), $urandom_range(0, 31),
				$urandom_range(1, 8), $urandom_range(1, 8),
				int'($urandom_range(0, 16383)) - 8192, int'($urandom_range(0, 16383)) - 8192);
			random_items(60);
			drain();
		end

		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
